// ===== rtl/core/terrain_patch_strip_index_gen_unit_defines.svh =====
// Assertion macros for the terrain patch strip index generator.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef TERRAIN_PATCH_STRIP_INDEX_GEN_UNIT_DEFINES_SVH
`define TERRAIN_PATCH_STRIP_INDEX_GEN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TPSI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpsi checker: property violated");

// Next-cycle implication, disabled in reset.
`define TPSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpsi checker: property violated");

`endif

// ===== rtl/core/tpsi_pkg.sv =====
// Shared types, constants and mode helpers of the strip index generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpsi_pkg;

  localparam int unsigned COORD_W = 13;  // grid coordinate incl. patch offset
  localparam int unsigned ROW_W   = 13;  // row_width register
  localparam int unsigned IDX_W   = 25;  // vertex index
  localparam int unsigned OFS_W   = 6;   // offset inside a patch
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 13'd257;

  // request kinds
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  // neighbor relations
  localparam logic [1:0] REL_SAME = 2'd0;
  localparam logic [1:0] REL_DBL  = 2'd1;
  localparam logic [1:0] REL_HALF = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x_start;
    logic [11:0] z_start;
    logic [1:0]  lod_shift;
    logic [1:0]  neighbor_relation;
    logic [3:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [24:0] vertex_index;
    logic        last;
    logic        error;
  } out_item_t;

  typedef enum logic [2:0] {
    MD_BODY,
    MD_R_SAME,
    MD_R_DBL,
    MD_R_HALF,
    MD_U_SAME,
    MD_U_DBL,
    MD_U_HALF
  } mode_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_LOOP,
    BK_TAIL,
    BK_ERR
  } bk_state_e;

  // classified request, front to back
  typedef struct packed {
    logic             error;
    mode_e            mode;
    logic [1:0]       sh;
    logic [OFS_W-1:0] col_ofs;
    logic [OFS_W-1:0] d0;
    logic             loop_empty;
    logic [11:0]      x_start;
    logic [11:0]      z_start;
  } job_t;

  // one grid vertex to be turned into an index
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic               last;
    logic               error;
  } put_t;

  function automatic logic mode_has_head(mode_e m);
    logic r;
    case (m)
      MD_R_SAME, MD_U_DBL, MD_U_HALF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mode_tail_count(mode_e m);
    logic [1:0] r;
    case (m)
      MD_BODY: r = 2'd2;
      MD_R_DBL, MD_R_HALF, MD_U_SAME: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mode_last_phase(mode_e m);
    logic [1:0] r;
    case (m)
      MD_R_DBL, MD_R_HALF, MD_U_DBL, MD_U_HALF: r = 2'd3;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // loop stride is twice the step
  function automatic logic mode_dbl(mode_e m);
    logic r;
    case (m)
      MD_R_DBL, MD_U_DBL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // loop walks upward from zero
  function automatic logic mode_up(mode_e m);
    logic r;
    case (m)
      MD_U_SAME, MD_U_DBL, MD_U_HALF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/terrain_patch_strip_index_gen_unit.sv =====
// Top level of the terrain patch triangle strip index generator.
// Depends on tpsi_pkg, tpsi_front, tpsi_queue, tpsi_seq, tpsi_idx.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+----------------------------
//   in      | in  | in_valid_i / in_stall_o | tpsi_pkg::in_item_t
//   out     | out | out_valid_o/out_stall_i | tpsi_pkg::out_item_t
//   cfg     | in  | cfg_valid_i/cfg_ready_o | row_width, 13 bit
//
// A request occupies the sequencer while it picks up the job in its idle state,
// then puts out one index per cycle while the index stage is ready (up to 34
// at a 17x17 patch); a rejected request puts out a single error index. The
// sequencer is the rate limit; two register stages follow it to the out port.
// Async active-low reset; no memory clearing pass after reset.
// The two-entry job queue keeps taking requests while the back end works
// or the out port is stalled; in_stall_o rises only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module terrain_patch_strip_index_gen_unit #(
  parameter int unsigned PATCH_EDGE  = 17,
  parameter int unsigned LEVEL_COUNT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tpsi_pkg::in_item_t         in_data_i,
  // index channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tpsi_pkg::out_item_t        out_data_o,
  // row width register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tpsi_pkg::ROW_W-1:0] cfg_data_i
);
  import tpsi_pkg::*;

  logic [ROW_W-1:0] row_width_q, row_width_d;
  job_t             front_job;
  job_t             q_job;
  logic             q_full, q_empty, q_pop;
  logic             put_valid, put_ready;
  put_t             put;

  // Register write is always accepted; software must write only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;
  assign row_width_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
    end else begin
      row_width_q <= row_width_d;
    end
  end

  // Front end: check and classify each request in the cycle it arrives.
  tpsi_front #(
    .PATCH_EDGE (PATCH_EDGE),
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_front (
    .req_i(in_data_i),
    .job_o(front_job)
  );

  assign in_stall_o = q_full;

  tpsi_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(front_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (q_job)
  );

  // Back end: vertex sequencer followed by the index multiply/add stages.
  tpsi_seq #(
    .PATCH_EDGE(PATCH_EDGE)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .job_i      (q_job),
    .job_pop_o  (q_pop),
    .put_valid_o(put_valid),
    .put_ready_i(put_ready),
    .put_o      (put)
  );

  tpsi_idx u_idx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_width_i(row_width_q),
    .put_valid_i(put_valid),
    .put_ready_o(put_ready),
    .put_i      (put),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tpsi_front.sv =====
// Request checker and classifier: turns a request into a job descriptor.
// Depends on tpsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpsi_front #(
  parameter int unsigned PATCH_EDGE  = 17,
  parameter int unsigned LEVEL_COUNT = 4
) (
  input  tpsi_pkg::in_item_t req_i,
  output tpsi_pkg::job_t     job_o
);
  import tpsi_pkg::*;

  logic [OFS_W-1:0] lw;
  logic [OFS_W-1:0] sw;
  logic [4:0]       col_p2;
  logic [7:0]       col_span;
  logic [OFS_W:0]   d0_full;
  logic             bad;
  mode_e            mode;

  always_comb begin
    lw       = OFS_W'(1) << req_i.lod_shift;
    col_p2   = {1'b0, req_i.column} + 5'd2;
    col_span = {3'b000, col_p2} << req_i.lod_shift;
    bad      = ({1'b0, req_i.lod_shift} >= 3'(LEVEL_COUNT));
    mode     = MD_BODY;
    case (req_i.kind)
      KIND_BODY: begin
        if (col_span >= 8'(PATCH_EDGE)) bad = 1'b1;
      end
      KIND_RIGHT: begin
        case (req_i.neighbor_relation)
          REL_SAME: mode = MD_R_SAME;
          REL_DBL:  mode = MD_R_DBL;
          REL_HALF: mode = MD_R_HALF;
          default:  bad  = 1'b1;
        endcase
      end
      KIND_UPPER: begin
        case (req_i.neighbor_relation)
          REL_SAME: mode = MD_U_SAME;
          REL_DBL:  mode = MD_U_DBL;
          REL_HALF: mode = MD_U_HALF;
          default:  bad  = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (req_i.kind != KIND_BODY && req_i.neighbor_relation == REL_HALF &&
        req_i.lod_shift == 2'd0) begin
      bad = 1'b1;
    end

    sw      = mode_dbl(mode) ? (lw << 1) : lw;
    d0_full = (OFS_W + 1)'(PATCH_EDGE - 1) - {1'b0, sw};

    job_o.error   = bad;
    job_o.mode    = mode;
    job_o.sh      = req_i.lod_shift;
    job_o.col_ofs = OFS_W'({2'b00, req_i.column} << req_i.lod_shift);
    job_o.x_start = req_i.x_start;
    job_o.z_start = req_i.z_start;
    if (mode_up(mode)) begin
      job_o.d0         = '0;
      job_o.loop_empty = ({1'b0, lw} >= (OFS_W + 1)'(PATCH_EDGE));
    end else begin
      // negative start means no iteration
      job_o.d0         = d0_full[OFS_W-1:0];
      job_o.loop_empty = d0_full[OFS_W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpsi_queue.sv =====
// Two-entry job queue between the classifier and the sequencer.
// Depends on tpsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpsi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpsi_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tpsi_pkg::job_t pop_data_o
);
  import tpsi_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpsi_seq.sv =====
// Strip sequencer: walks head, loop phases and tail of one job (or one error
// vertex), one grid vertex per cycle while put_ready_i is high. Depends on tpsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpsi_seq #(
  parameter int unsigned PATCH_EDGE = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  tpsi_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           put_valid_o,
  input  logic           put_ready_i,
  output tpsi_pkg::put_t put_o
);
  import tpsi_pkg::*;

  localparam logic [OFS_W-1:0] PM1 = OFS_W'(PATCH_EDGE - 1);

  bk_state_e        state_q, state_d;
  job_t             job_q, job_d;
  logic [OFS_W-1:0] d_q, d_d;
  logic [1:0]       ph_q, ph_d;

  logic [OFS_W-1:0] lw, hw, sw, c, d_next;
  logic [OFS_W-1:0] ox, oz;
  logic [OFS_W:0]   lim, dsum;
  logic             last_iter, fire, is_last;
  logic [1:0]       last_ph, tails;

  always_comb begin
    lw        = OFS_W'(1) << job_q.sh;
    hw        = lw >> 1;
    sw        = mode_dbl(job_q.mode) ? (lw << 1) : lw;
    c         = job_q.col_ofs;
    lim       = (OFS_W + 1)'(PATCH_EDGE) - {1'b0, lw};
    dsum      = {1'b0, d_q} + {1'b0, sw};
    last_ph   = mode_last_phase(job_q.mode);
    tails     = mode_tail_count(job_q.mode);
    if (mode_up(job_q.mode)) begin
      last_iter = (dsum >= lim);
      d_next    = d_q + sw;
    end else begin
      last_iter = (d_q < sw);
      d_next    = d_q - sw;
    end
  end

  // vertex offsets (z, x) inside the patch
  always_comb begin
    oz      = '0;
    ox      = '0;
    is_last = 1'b0;
    case (state_q)
      BK_HEAD: begin
        oz      = (job_q.mode == MD_R_SAME) ? PM1 : '0;
        ox      = PM1;
        is_last = job_q.loop_empty && (tails == 2'd0);
      end
      BK_LOOP: begin
        is_last = last_iter && (ph_q == last_ph) && (tails == 2'd0);
        case (job_q.mode)
          MD_BODY: begin
            oz = d_q;
            ox = (ph_q == 2'd0) ? c : c + lw;
          end
          MD_R_SAME: begin
            oz = (ph_q == 2'd0) ? PM1 - lw : PM1;
            ox = d_q;
          end
          MD_R_DBL: begin
            case (ph_q)
              2'd0:    begin oz = PM1;      ox = d_q + sw; end
              2'd1:    begin oz = PM1 - lw; ox = d_q + lw; end
              2'd2:    begin oz = PM1;      ox = d_q + sw; end
              default: begin oz = PM1 - lw; ox = d_q;      end
            endcase
          end
          MD_R_HALF: begin
            case (ph_q)
              2'd0:    begin oz = PM1;      ox = d_q + lw; end
              2'd1:    begin oz = PM1 - lw; ox = d_q;      end
              2'd2:    begin oz = PM1;      ox = d_q + hw; end
              default: begin oz = PM1 - lw; ox = d_q;      end
            endcase
          end
          MD_U_SAME: begin
            oz = d_q;
            ox = (ph_q == 2'd0) ? PM1 : PM1 - lw;
          end
          MD_U_DBL: begin
            case (ph_q)
              2'd0:    begin oz = d_q;      ox = PM1 - lw; end
              2'd1:    begin oz = d_q + sw; ox = PM1;      end
              2'd2:    begin oz = d_q + lw; ox = PM1 - lw; end
              default: begin oz = d_q + sw; ox = PM1;      end
            endcase
          end
          MD_U_HALF: begin
            case (ph_q)
              2'd0:    begin oz = d_q;      ox = PM1 - lw; end
              2'd1:    begin oz = d_q + hw; ox = PM1;      end
              2'd2:    begin oz = d_q;      ox = PM1 - lw; end
              default: begin oz = d_q + lw; ox = PM1;      end
            endcase
          end
          default: begin
            oz = '0;
            ox = '0;
          end
        endcase
      end
      BK_TAIL: begin
        is_last = (ph_q == tails - 2'd1);
        case (job_q.mode)
          MD_BODY: begin
            // repeat of the last strip vertex, then back to the strip top
            oz = (ph_q == 2'd0) ? (PM1 & (lw - 1'b1)) : PM1 - lw;
            ox = c + lw;
          end
          MD_U_SAME: begin
            oz = PM1;
            ox = PM1;
          end
          default: begin
            oz = PM1;
            ox = '0;
          end
        endcase
      end
      BK_ERR: is_last = 1'b1;
      default: is_last = 1'b0;
    endcase
  end

  always_comb begin
    put_valid_o = (state_q != BK_IDLE);
    put_o.last  = is_last;
    put_o.error = (state_q == BK_ERR);
    if (state_q == BK_ERR) begin
      put_o.x = '0;
      put_o.z = '0;
    end else begin
      put_o.x = {1'b0, job_q.x_start} + COORD_W'(ox);
      put_o.z = {1'b0, job_q.z_start} + COORD_W'(oz);
    end
  end

  assign fire = put_valid_o && put_ready_i;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    d_d       = d_q;
    ph_d      = ph_q;
    job_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          d_d       = job_i.d0;
          ph_d      = 2'd0;
          if (job_i.error) begin
            state_d = BK_ERR;
          end else if (mode_has_head(job_i.mode)) begin
            state_d = BK_HEAD;
          end else if (!job_i.loop_empty) begin
            state_d = BK_LOOP;
          end else begin
            state_d = BK_TAIL;
          end
        end
      end
      BK_HEAD: begin
        if (fire) begin
          if (!job_q.loop_empty) begin
            state_d = BK_LOOP;
          end else if (tails != 2'd0) begin
            state_d = BK_TAIL;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_LOOP: begin
        if (fire) begin
          if (ph_q != last_ph) begin
            ph_d = ph_q + 2'd1;
          end else if (last_iter) begin
            ph_d    = 2'd0;
            state_d = (tails != 2'd0) ? BK_TAIL : BK_IDLE;
          end else begin
            ph_d = 2'd0;
            d_d  = d_next;
          end
        end
      end
      BK_TAIL: begin
        if (fire) begin
          if (is_last) begin
            state_d = BK_IDLE;
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end
      end
      BK_ERR: begin
        if (fire) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    d_q   <= d_d;
    ph_q  <= ph_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpsi_idx.sv =====
// Index datapath: x times row width, then plus z, with output register.
// Depends on tpsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpsi_idx (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tpsi_pkg::ROW_W-1:0] row_width_i,
  input  logic                       put_valid_i,
  output logic                       put_ready_o,
  input  tpsi_pkg::put_t             put_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tpsi_pkg::out_item_t        out_o
);
  import tpsi_pkg::*;

  logic                     s2_valid_q;
  logic [COORD_W-1:0]       s2_z_q;
  logic [IDX_W-1:0]         s2_prod_q;
  logic                     s2_last_q, s2_err_q;
  logic                     out_valid_q;
  out_item_t                out_q;
  logic [COORD_W+ROW_W-1:0] prod_full;
  logic                     out_ready;
  logic                     s2_load, out_load;

  assign prod_full   = {{ROW_W{1'b0}}, put_i.x} * {{COORD_W{1'b0}}, row_width_i};
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign put_ready_o = !s2_valid_q || out_ready;
  assign s2_load     = put_valid_i && put_ready_o;
  assign out_load    = s2_valid_q && out_ready;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (put_ready_o) s2_valid_q <= put_valid_i;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_z_q    <= put_i.z;
      s2_prod_q <= prod_full[IDX_W-1:0];
      s2_last_q <= put_i.last;
      s2_err_q  <= put_i.error;
    end
    if (out_load) begin
      out_q.vertex_index <= {{(IDX_W - COORD_W){1'b0}}, s2_z_q} + s2_prod_q;
      out_q.last         <= s2_last_q;
      out_q.error        <= s2_err_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpsi_checker.sv =====
// Port-level checker for the strip index generator, bound to the top level.
// Depends on tpsi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "terrain_patch_strip_index_gen_unit_defines.svh"
module tpsi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_i,
  input tpsi_pkg::in_item_t         in_data_i,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input tpsi_pkg::out_item_t        out_data_i,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i,
  input logic [tpsi_pkg::ROW_W-1:0] cfg_data_i
);
  import tpsi_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_data_i, cfg_valid_i, cfg_ready_i, cfg_data_i};

  // a rejected request is a single zero index that closes its run
  `TPSI_ASSERT_SAME(a_err_single, out_valid_i && out_data_i.error, out_data_i.last && (out_data_i.vertex_index == '0))

  // a stalled result stays put
  `TPSI_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))

  // the queue only fills up through an accepted request
  `TPSI_ASSERT_SAME(a_stall_rise, $rose(in_stall_i), $past(in_valid_i && !in_stall_i))

endmodule

bind terrain_patch_strip_index_gen_unit tpsi_checker u_tpsi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_i(cfg_ready_o),
  .cfg_data_i (cfg_data_i)
);
`default_nettype wire

// ===== test/tb_terrain_patch_strip_index_gen_unit.sv =====
// Self-checking testbench for terrain_patch_strip_index_gen_unit.
// Needs only tpsi_pkg and the RTL; directed table first, then random requests
// under several row_width settings, checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_terrain_patch_strip_index_gen_unit;
  import tpsi_pkg::*;

  localparam int PATCH_EDGE  = 17;
  localparam int LEVEL_COUNT = 4;
  localparam int MAX_RUN     = 34;       // longest index run per request
  localparam int DRAIN_CYCLES = 8;       // two output stages plus margin
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 64;
  localparam int PHASES      = 6;

  // codes the package leaves unnamed: the kind is always rejected, the relation on edge stitches
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam logic [1:0] REL_BAD  = 2'd3;

  // one row of the directed table; typed_err rows carry a known
  // single error result, every other row goes through the predictor
  typedef struct packed {
    logic     typed_err;
    in_item_t req;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // body columns: longest run, max column per step, the first bad column
    '{1'b0, '{KIND_BODY,  12'd0,    12'd0,    2'd0, REL_SAME, 4'd0}},
    '{1'b0, '{KIND_BODY,  12'd4095, 12'd4095, 2'd0, REL_BAD,  4'd14}},
    '{1'b1, '{KIND_BODY,  12'd5,    12'd7,    2'd0, REL_SAME, 4'd15}},
    '{1'b0, '{KIND_BODY,  12'd0,    12'd4095, 2'd3, REL_DBL,  4'd0}},
    '{1'b1, '{KIND_BODY,  12'd0,    12'd0,    2'd3, REL_SAME, 4'd1}},
    '{1'b0, '{KIND_BODY,  12'd100,  12'd200,  2'd2, REL_HALF, 4'd2}},
    '{1'b1, '{KIND_BODY,  12'd100,  12'd200,  2'd2, REL_SAME, 4'd3}},
    '{1'b0, '{KIND_BODY,  12'd4095, 12'd0,    2'd1, REL_SAME, 4'd6}},
    '{1'b1, '{KIND_BODY,  12'd4095, 12'd0,    2'd1, REL_SAME, 4'd7}},
    // right edge stitches
    '{1'b0, '{KIND_RIGHT, 12'd0,    12'd0,    2'd0, REL_SAME, 4'd15}},
    '{1'b0, '{KIND_RIGHT, 12'd4095, 12'd4095, 2'd0, REL_DBL,  4'd0}},
    '{1'b1, '{KIND_RIGHT, 12'd10,   12'd20,   2'd0, REL_HALF, 4'd0}},
    '{1'b0, '{KIND_RIGHT, 12'd1234, 12'd321,  2'd1, REL_HALF, 4'd5}},
    '{1'b0, '{KIND_RIGHT, 12'd4095, 12'd4095, 2'd3, REL_HALF, 4'd0}},
    '{1'b0, '{KIND_RIGHT, 12'd0,    12'd0,    2'd3, REL_DBL,  4'd0}},
    '{1'b1, '{KIND_RIGHT, 12'd50,   12'd60,   2'd2, REL_BAD,  4'd0}},
    // upper edge stitches
    '{1'b0, '{KIND_UPPER, 12'd0,    12'd0,    2'd0, REL_SAME, 4'd0}},
    '{1'b0, '{KIND_UPPER, 12'd4095, 12'd4095, 2'd3, REL_DBL,  4'd15}},
    '{1'b1, '{KIND_UPPER, 12'd33,   12'd44,   2'd0, REL_HALF, 4'd0}},
    '{1'b0, '{KIND_UPPER, 12'd777,  12'd888,  2'd2, REL_HALF, 4'd9}},
    '{1'b0, '{KIND_UPPER, 12'd2048, 12'd1,    2'd0, REL_DBL,  4'd0}},
    '{1'b0, '{KIND_UPPER, 12'd1,    12'd2048, 2'd3, REL_SAME, 4'd0}},
    // unknown kind, unknown relation
    '{1'b1, '{KIND_BAD,   12'd4095, 12'd4095, 2'd3, REL_BAD,  4'd15}},
    '{1'b1, '{KIND_UPPER, 12'd0,    12'd0,    2'd0, REL_BAD,  4'd0}}
  };

  // DUT-facing signals; the driven inputs are known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [ROW_W-1:0]     cfg_data_i  = '0;

  // predictor state and bookkeeping
  logic [ROW_W-1:0] row_width_q = ROW_WIDTH_RST;
  out_item_t        expected_indices [$];  // indices still owed by the DUT
  out_item_t        strip_run [$];         // scratch for one request's run
  int               sender_idle_pct   = 0;
  int               receiver_idle_pct = 0;
  int               fail_count      = 0;
  int               requests_sent   = 0;
  int               rejected_count  = 0;
  int               indices_checked = 0;
  int               widths_used     = 1;
  int               cycle_count     = 0;

  always #4 clk_i = ~clk_i;

  terrain_patch_strip_index_gen_unit #(
    .PATCH_EDGE  (PATCH_EDGE),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Grid vertex (z, x) -> index z + x * row_width, wrapped to 25 bits.
  // Anything past the longest legal run is dropped.
  function automatic void add_vertex(input int z, input int x);
    out_item_t     item;
    longint unsigned full;
    full = longint'(z) + longint'(x) * longint'(row_width_q);
    item.vertex_index = full[IDX_W-1:0];
    item.last  = 1'b0;
    item.error = 1'b0;
    if (strip_run.size() < MAX_RUN) strip_run.push_back(item);
  endfunction

  // Expands one request into its strip run and queues it.
  function automatic void predict_strip_indices(input in_item_t req);
    int        xs, zs, xe, ze, step, half, col, d, x, z, lastz;
    logic      reject;
    out_item_t err_item;
    xs    = req.x_start;
    zs    = req.z_start;
    xe    = xs + PATCH_EDGE;
    ze    = zs + PATCH_EDGE;
    step  = 1 << req.lod_shift;
    half  = step / 2;
    col   = req.column;
    lastz = 0;
    reject = (req.kind == KIND_BAD) || (req.lod_shift >= LEVEL_COUNT);
    if (req.kind == KIND_BODY)
      reject |= ((col + 2) * step >= PATCH_EDGE);
    else
      reject |= (req.neighbor_relation == REL_BAD) ||
                (req.neighbor_relation == REL_HALF && req.lod_shift == 2'd0);
    if (reject) begin
      err_item = '{vertex_index: '0, last: 1'b1, error: 1'b1};
      expected_indices.push_back(err_item);
      rejected_count++;
      return;
    end
    strip_run.delete();
    if (req.kind == KIND_BODY) begin
      // column strip walks z downward, then two degenerate indices
      x = xs + col * step;
      for (d = PATCH_EDGE - 1 - step; d >= 0; d -= step) begin
        add_vertex(zs + d, x);
        add_vertex(zs + d, x + step);
        lastz = zs + d;
      end
      add_vertex(lastz, x + step);
      add_vertex(ze - 1 - step, x + step);
    end else if (req.kind == KIND_RIGHT) begin
      case (req.neighbor_relation)
        REL_SAME: begin
          add_vertex(ze - 1, xe - 1);
          for (d = PATCH_EDGE - 1 - step; d >= 0; d -= step) begin
            add_vertex(ze - 1 - step, xs + d);
            add_vertex(ze - 1, xs + d);
          end
        end
        REL_DBL: begin
          for (d = PATCH_EDGE - 1 - 2 * step; d >= 0; d -= 2 * step) begin
            x = xs + d;
            add_vertex(ze - 1, x + 2 * step);
            add_vertex(ze - 1 - step, x + step);
            add_vertex(ze - 1, x + 2 * step);
            add_vertex(ze - 1 - step, x);
          end
          add_vertex(ze - 1, xs);
        end
        default: begin
          for (d = PATCH_EDGE - 1 - step; d >= 0; d -= step) begin
            x = xs + d;
            add_vertex(ze - 1, x + step);
            add_vertex(ze - 1 - step, x);
            add_vertex(ze - 1, x + half);
            add_vertex(ze - 1 - step, x);
          end
          add_vertex(ze - 1, xs);
        end
      endcase
    end else begin
      case (req.neighbor_relation)
        REL_SAME: begin
          for (d = 0; d < PATCH_EDGE - step; d += step) begin
            add_vertex(zs + d, xe - 1);
            add_vertex(zs + d, xe - 1 - step);
          end
          add_vertex(ze - 1, xe - 1);
        end
        REL_DBL: begin
          add_vertex(zs, xe - 1);
          for (d = 0; d < PATCH_EDGE - step; d += 2 * step) begin
            z = zs + d;
            add_vertex(z, xe - 1 - step);
            add_vertex(z + 2 * step, xe - 1);
            add_vertex(z + step, xe - 1 - step);
            add_vertex(z + 2 * step, xe - 1);
          end
        end
        default: begin
          add_vertex(zs, xe - 1);
          for (d = 0; d < PATCH_EDGE - step; d += step) begin
            z = zs + d;
            add_vertex(z, xe - 1 - step);
            add_vertex(z + half, xe - 1);
            add_vertex(z, xe - 1 - step);
            add_vertex(z + step, xe - 1);
          end
        end
      endcase
    end
    strip_run[strip_run.size() - 1].last = 1'b1;
    foreach (strip_run[i]) expected_indices.push_back(strip_run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // origin coordinate with the grid edges favored
  function automatic logic [11:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 12'd0;
    if (sel == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  // Mostly legal requests with random content; a slice is rejected on
  // purpose and a few are pure random bits.
  function automatic in_item_t random_request();
    in_item_t req;
    int       sel;
    req.x_start           = pick_coord();
    req.z_start           = pick_coord();
    req.lod_shift         = 2'($urandom_range(0, 3));
    req.neighbor_relation = 2'($urandom_range(0, 2));
    req.column            = 4'($urandom);
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      req.kind = KIND_BODY;
      // keep the column legal for this step most of the time
      if (sel != 0) req.column = 4'($urandom_range(0, (16 >> req.lod_shift) - 2));
      if (sel == 1) req.neighbor_relation = REL_BAD;   // ignored on body
    end else if (sel < 18) begin
      req.kind = (sel < 13) ? KIND_RIGHT : KIND_UPPER;
      if ($urandom_range(0, 9) == 0) req.neighbor_relation = REL_BAD;
    end else if (sel == 18) begin
      req.kind = KIND_BAD;
    end else begin
      req = in_item_t'({$urandom, $urandom});
    end
    return req;
  endfunction

  // Offer one request, with random sender gaps ahead of it, and book its
  // expected run once the transfer happens. Valid stays up afterwards so
  // back-to-back requests need no extra edge.
  task automatic issue_request(input in_item_t req, input logic typed_err);
    out_item_t err_item;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (typed_err) begin
      err_item = '{vertex_index: '0, last: 1'b1, error: 1'b1};
      expected_indices.push_back(err_item);
      rejected_count++;
    end else begin
      predict_strip_indices(req);
    end
    requests_sent++;
  endtask

  // Every request yields at least one index, so an empty queue plus the
  // output pipeline depth means the block is idle.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_indices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_row_width(input logic [ROW_W-1:0] width);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= width;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    row_width_q = width;
    widths_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall and output checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_indices.size() == 0) begin
        $display("%0t: index transfer with nothing expected: idx=%0d last=%0b err=%0b",
                 $time, out_data_o.vertex_index, out_data_o.last, out_data_o.error);
        fail_count++;
      end else begin
        want = expected_indices.pop_front();
        if (out_data_o.vertex_index !== want.vertex_index) begin
          $display("%0t: vertex_index expected %0d actual %0d",
                   $time, want.vertex_index, out_data_o.vertex_index);
          fail_count++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_data_o.last);
          fail_count++;
        end
        if (out_data_o.error !== want.error) begin
          $display("%0t: error expected %0b actual %0b", $time, want.error, out_data_o.error);
          fail_count++;
        end
        indices_checked++;
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d indices outstanding",
               $time, cycle_count, expected_indices.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [ROW_W-1:0] phase_widths [PHASES];
    // extremes of the register, one value outside its usual range, a
    // random one, and back to the reset value
    phase_widths = '{13'd2, 13'd4096, 13'h1FFF, 13'd0,
                     13'($urandom_range(2, 4096)), ROW_WIDTH_RST};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset row_width
    sender_idle_pct   = 26;
    receiver_idle_pct = 61;
    for (int i = 0; i < DIR_ROWS; i++)
      issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed_err);

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin sender_idle_pct = 26; receiver_idle_pct = 61; end
        1: begin sender_idle_pct = 61; receiver_idle_pct = 26; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      wait_for_drain();
      write_row_width(phase_widths[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) issue_request(random_request(), 1'b0);
    end

    wait_for_drain();
    $display("Covered %0d requests (%0d rejected), %0d indices checked,",
             requests_sent, rejected_count, indices_checked);
    $display("all request kinds and relations across %0d row_width settings.",
             widths_used);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
